// ----- hdl/coxsr_pkg.sv -----
// Shared constants, codes and record types for the Cox Schoenfeld residual block.
// No dependencies; imported by the request and register interfaces and every module.
`default_nettype none
package coxsr_pkg;
   localparam int MAX_SUBJECTS   = 1024;
   localparam int MAX_COVARIATES = 8;
   localparam int SUBJ_W  = $clog2(MAX_SUBJECTS);
   localparam int COV_W   = $clog2(MAX_COVARIATES);
   localparam int CNT_W   = SUBJ_W + 1;
   localparam int ELEM_W  = 4;
   localparam int CA_W    = SUBJ_W + COV_W;
   localparam int DIV_W   = 128;
   localparam int DCNT_W  = $clog2(DIV_W + 1);
   localparam int Q_FRAC  = 16;
   localparam int KF_W    = CNT_W + 1;
   localparam int MUL_A_W = 66;
   localparam int MUL_P_W = MUL_A_W + KF_W;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 4;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NONE  = 2'd1;
   localparam logic [1:0] STATUS_ZDIV  = 2'd2;

   localparam logic [1:0] MARK_NONE = 2'b00;
   localparam logic [1:0] MARK_SAT  = 2'b01;
   localparam logic [1:0] MARK_ZDIV = 2'b10;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COV = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EFRON   = CSR_IDX_W'(1);

   typedef struct packed {
      logic        strat_end;
      logic        evt;
      logic [31:0] score;
      logic [31:0] stop;
      logic [31:0] start;
   } subj_rec_type;
endpackage
`default_nettype wire

// ----- hdl/coxsr_req_if.sv -----
// Input channel: load and read items with valid/ready.
// Depends on coxsr_pkg.
`default_nettype none
interface coxsr_req_if import coxsr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [31:0]             start_time;
   logic [31:0]             stop_time;
   logic                    event_flag;
   logic                    stratum_end;
   logic [31:0]             risk_score;
   logic signed [31:0]      covariate_value;
   logic                    last_covariate;
   logic                    last_subject;
   logic [SUBJ_W-1:0]       read_subject;
   logic [COV_W-1:0]        read_covariate;
   modport source (output valid, kind, start_time, stop_time, event_flag, stratum_end,
                   risk_score, covariate_value, last_covariate, last_subject,
                   read_subject, read_covariate, input ready);
   modport sink (input valid, kind, start_time, stop_time, event_flag, stratum_end,
                 risk_score, covariate_value, last_covariate, last_subject,
                 read_subject, read_covariate, output ready);
endinterface
`default_nettype wire

// ----- hdl/coxsr_rsp_if.sv -----
// Result channel: one table entry per read item, valid/ready.
// No dependencies.
`default_nettype none
interface coxsr_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [31:0] residual_value;
   logic               is_death;
   logic               saturated;
   logic [1:0]         status;
   modport source (output valid, residual_value, is_death, saturated, status, input ready);
   modport sink (input valid, residual_value, is_death, saturated, status, output ready);
endinterface
`default_nettype wire

// ----- hdl/coxsr_csr_if.sv -----
// Configuration write channel: register index and data, valid/ready.
// Depends on coxsr_pkg.
`default_nettype none
interface coxsr_csr_if import coxsr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/coxsr_div.sv -----
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Depends on coxsr_pkg.
`default_nettype none
module coxsr_div import coxsr_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] num,
   input  wire logic [DIV_W-1:0] den,
   output logic                  done,
   output logic [DIV_W-1:0]      quot
);
   logic [DIV_W-1:0]  n_ff, n_in, d_ff, d_in, q_ff, q_in, r_ff, r_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIV_W:0]    rs, rd;

   always_comb begin
      n_in = n_ff; d_in = d_ff; q_in = q_ff; r_in = r_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      rs = {r_ff, n_ff[DIV_W-1]};
      rd = rs - {1'b0, d_ff};
      if (start) begin
         n_in = num; d_in = den; q_in = '0; r_in = '0;
         cnt_in = DCNT_W'(DIV_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = {n_ff[DIV_W-2:0], 1'b0};
         if (!rd[DIV_W]) begin
            r_in = rd[DIV_W-1:0];
            q_in = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            r_in = rs[DIV_W-1:0];
            q_in = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; d_ff <= d_in; q_ff <= q_in; r_ff <= r_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ----- hdl/cox_schoenfeld_residuals.sv -----
// Schoenfeld residuals of a Cox model, Breslow or Efron ties, Q16.16 fixed point.
// Depends on coxsr_pkg, the three channel interfaces and coxsr_div.
//
// Load items are taken one per cycle while no result waits unaccepted, filling
// the subject and covariate tables. The item carrying last_subject starts the
// computation; the block takes no item until it ends. For each death time the
// sequencer walks from the first death to the end of the stratum, visiting states
// RK, RKD, RPOST per subject and RC, RCM, RCA per covariate of each subject at
// risk. Each covariate of each dying subject then uses the 128-step shared divider.
// A read item is answered via the RD state. Configuration writes are always taken.
`default_nettype none
module cox_schoenfeld_residuals import coxsr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   coxsr_req_if.sink   req_chan,
   coxsr_rsp_if.source rsp_chan,
   coxsr_csr_if.sink   csr_chan
);
   localparam logic [4:0] ST_IDLE = 5'd0,  ST_RD = 5'd1,    ST_PREP = 5'd2,  ST_HEAD = 5'd3,
                          ST_RK = 5'd4,    ST_RKD = 5'd5,   ST_RC = 5'd6,    ST_RCM = 5'd7,
                          ST_RCA = 5'd8,   ST_RPOST = 5'd9, ST_KF = 5'd10,   ST_DEN0 = 5'd11,
                          ST_DEN1 = 5'd12, ST_UK = 5'd13,   ST_UKD = 5'd14,  ST_UC = 5'd15,
                          ST_UN = 5'd16,   ST_UN2 = 5'd17,  ST_DIV = 5'd18,  ST_RES = 5'd19,
                          ST_WR = 5'd20,   ST_UNEXT = 5'd21, ST_UPOST = 5'd22;

   subj_rec_type subj_mem [MAX_SUBJECTS];
   logic [31:0]  cov_mem  [MAX_SUBJECTS*MAX_COVARIATES];
   logic [2*MAX_COVARIATES-1:0] mark_mem [MAX_SUBJECTS];
   subj_rec_type subj_rd_ff, subj_wd;
   logic [31:0]  cov_rd_ff, cov_wd;
   logic [2*MAX_COVARIATES-1:0] mark_rd_ff;
   logic [SUBJ_W-1:0] subj_ra, subj_wa, mark_wa;
   logic [CA_W-1:0]   cov_ra, cov_wa;
   logic [COV_W-1:0]  mark_wc, rd_cov_ff, rd_cov_in;
   logic [1:0]        mark_wd, rd_mark;
   logic              subj_we, cov_we, mark_we, mark_clr;

   logic [4:0]        st_ff, st_in;
   logic              phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in, p_ff, p_in, k_ff, k_in, d_ff, d_in;
   logic [ELEM_W-1:0] elem_ff, elem_in, i_ff, i_in, nv;
   logic [ELEM_W-1:0] num_cov_ff;
   logic              efron_ff;
   logic [31:0]       dtime_ff, dtime_in, w_ff, w_in, cov_v_ff, cov_v_in;
   logic              dies_ff, dies_in, send_ff, send_in, neg_ff, neg_in, rd_ok_ff, rd_ok_in;
   logic [63:0]       den0_ff, den0_in, den1_ff, den1_in;
   logic [63:0]       risk_ff [MAX_COVARIATES];
   logic [63:0]       risk_in [MAX_COVARIATES];
   logic [63:0]       death_ff [MAX_COVARIATES];
   logic [63:0]       death_in [MAX_COVARIATES];
   logic signed [KF_W-1:0]    kf_ff, kf_in;
   logic signed [64:0]        prod1_ff, prod1_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_P_W-1:0] mprod_ff, mprod_in;
   logic [DIV_W-1:0]  den2_ff, den2_in, r_ff, r_in, num2, nsh, absn, absd, cov_ext;
   logic [63:0]       term;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;
   logic              rsp_death_ff, rsp_death_in, rsp_sat_ff, rsp_sat_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              div_start, div_done;
   logic [DIV_W-1:0]  quot;
   logic [CNT_W-1:0]  cnt;
   logic [ELEM_W-1:0] el;
   logic [COV_W-1:0]  ci;
   logic              req_xfer;

   coxsr_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(absn), .den(absd),
      .done(div_done), .quot(quot)
   );

   assign nv = (num_cov_ff > ELEM_W'(MAX_COVARIATES)) ? ELEM_W'(MAX_COVARIATES) : num_cov_ff;
   assign req_chan.ready = (st_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign ci = i_ff[COV_W-1:0];
   assign rd_mark = mark_rd_ff[{rd_cov_ff, 1'b0} +: 2];

   assign subj_ra = (st_ff == ST_IDLE) ? req_chan.read_subject :
                    (st_ff == ST_PREP) ? p_ff[SUBJ_W-1:0] : k_ff[SUBJ_W-1:0];
   assign cov_ra  = (st_ff == ST_IDLE) ? {req_chan.read_subject, req_chan.read_covariate}
                                       : {k_ff[SUBJ_W-1:0], ci};
   assign mul_a = (st_ff == ST_DEN0) ? $signed({2'b00, den1_ff})
                                     : $signed({{2{death_ff[ci][63]}}, death_ff[ci]});
   assign term = 64'(prod1_ff >>> Q_FRAC);
   assign num2 = {{63{risk_ff[ci][63]}}, risk_ff[ci], 1'b0}
               - {{(DIV_W-MUL_P_W){mprod_ff[MUL_P_W-1]}}, mprod_ff};
   assign nsh  = {num2[DIV_W-1-Q_FRAC:0], {Q_FRAC{1'b0}}};
   assign absn = nsh[DIV_W-1] ? -nsh : nsh;
   assign absd = den2_ff[DIV_W-1] ? -den2_ff : den2_ff;
   assign cov_ext = {{(DIV_W-32){cov_v_ff[31]}}, cov_v_ff};

   always_comb begin
      st_in = st_ff; phase_in = phase_ff; count_in = count_ff; elem_in = elem_ff;
      p_in = p_ff; k_in = k_ff; d_in = d_ff; i_in = i_ff;
      dtime_in = dtime_ff; w_in = w_ff; cov_v_in = cov_v_ff;
      dies_in = dies_ff; send_in = send_ff; neg_in = neg_ff; rd_ok_in = rd_ok_ff;
      rd_cov_in = rd_cov_ff;
      den0_in = den0_ff; den1_in = den1_ff; kf_in = kf_ff;
      prod1_in = prod1_ff; mprod_in = mprod_ff; den2_in = den2_ff; r_in = r_ff;
      risk_in = risk_ff; death_in = death_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_val_in = rsp_val_ff; rsp_death_in = rsp_death_ff;
      rsp_sat_in = rsp_sat_ff; rsp_status_in = rsp_status_ff;
      subj_we = 1'b0; cov_we = 1'b0; subj_wa = '0; cov_wa = '0;
      subj_wd = '0; cov_wd = '0; div_start = 1'b0;
      mark_we = 1'b0; mark_clr = 1'b0; mark_wa = '0; mark_wc = '0; mark_wd = MARK_NONE;
      cnt = phase_ff ? '0 : count_ff;
      el  = phase_ff ? '0 : elem_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_xfer && req_chan.kind == KIND_LOAD) begin
               phase_in = 1'b0;
               count_in = cnt;
               elem_in = el;
               if (cnt < CNT_W'(MAX_SUBJECTS)) begin
                  subj_we = 1'b1;
                  subj_wa = cnt[SUBJ_W-1:0];
                  subj_wd = '{strat_end: req_chan.stratum_end, evt: req_chan.event_flag,
                              score: req_chan.risk_score, stop: req_chan.stop_time,
                              start: req_chan.start_time};
                  mark_clr = 1'b1;
                  mark_wa = cnt[SUBJ_W-1:0];
                  if (el < nv) begin
                     cov_we = 1'b1;
                     cov_wa = {cnt[SUBJ_W-1:0], el[COV_W-1:0]};
                     cov_wd = req_chan.covariate_value;
                  end
                  if (el < ELEM_W'(MAX_COVARIATES)) elem_in = el + ELEM_W'(1);
                  if (req_chan.last_covariate || req_chan.last_subject) begin
                     count_in = cnt + CNT_W'(1);
                     elem_in = '0;
                  end
               end
               if (req_chan.last_subject) begin
                  p_in = '0;
                  st_in = ST_PREP;
               end
            end else if (req_xfer) begin
               rd_ok_in = phase_ff && ({1'b0, req_chan.read_subject} < count_ff)
                          && ({1'b0, req_chan.read_covariate} < nv);
               rd_cov_in = req_chan.read_covariate;
               st_in = ST_RD;
            end
         end
         ST_RD: begin
            rsp_valid_in = 1'b1;
            rsp_val_in = rd_ok_ff ? cov_rd_ff : '0;
            rsp_death_in = rd_ok_ff && subj_rd_ff.evt;
            rsp_sat_in = rd_ok_ff && rd_mark[0];
            rsp_status_in = !rd_ok_ff ? STATUS_NONE :
                            (rd_mark[1] ? STATUS_ZDIV : STATUS_OK);
            st_in = ST_IDLE;
         end
         ST_PREP: begin
            if (p_ff >= count_ff) begin
               phase_in = 1'b1;
               st_in = ST_IDLE;
            end else st_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (!subj_rd_ff.evt) begin
               p_in = p_ff + CNT_W'(1);
               st_in = ST_PREP;
            end else begin
               dtime_in = subj_rd_ff.stop;
               den0_in = '0; den1_in = '0; d_in = '0; k_in = p_ff;
               for (int j = 0; j < MAX_COVARIATES; j++) begin
                  risk_in[j] = '0;
                  death_in[j] = '0;
               end
               st_in = ST_RK;
            end
         end
         ST_RK: st_in = (k_ff >= count_ff) ? ST_KF : ST_RKD;
         ST_RKD: begin
            w_in = subj_rd_ff.score;
            dies_in = (subj_rd_ff.stop == dtime_ff) && subj_rd_ff.evt;
            send_in = subj_rd_ff.strat_end;
            i_in = '0;
            st_in = ST_RPOST;
            if (subj_rd_ff.start < dtime_ff) begin
               den0_in = den0_ff + {32'b0, subj_rd_ff.score};
               if ((subj_rd_ff.stop == dtime_ff) && subj_rd_ff.evt) begin
                  d_in = d_ff + CNT_W'(1);
                  den1_in = den1_ff + {32'b0, subj_rd_ff.score};
               end
               if (nv != '0) st_in = ST_RC;
            end
         end
         ST_RC: st_in = ST_RCM;
         ST_RCM: begin
            prod1_in = $signed({1'b0, w_ff}) * $signed(cov_rd_ff);
            st_in = ST_RCA;
         end
         ST_RCA: begin
            risk_in[ci] = risk_ff[ci] + term;
            if (dies_ff) death_in[ci] = death_ff[ci] + term;
            i_in = i_ff + ELEM_W'(1);
            st_in = (i_ff + ELEM_W'(1) < nv) ? ST_RC : ST_RPOST;
         end
         ST_RPOST: begin
            if (send_ff) st_in = ST_KF;
            else begin
               k_in = k_ff + CNT_W'(1);
               st_in = ST_RK;
            end
         end
         ST_KF: begin
            kf_in = efron_ff ? $signed({1'b0, d_ff} - KF_W'(1)) : '0;
            st_in = ST_DEN0;
         end
         ST_DEN0: begin
            mprod_in = mul_a * kf_ff;
            st_in = ST_DEN1;
         end
         ST_DEN1: begin
            den2_in = {63'b0, den0_ff, 1'b0}
                    - {{(DIV_W-MUL_P_W){mprod_ff[MUL_P_W-1]}}, mprod_ff};
            k_in = p_ff;
            st_in = ST_UK;
         end
         ST_UK: st_in = (k_ff >= count_ff) ? ST_PREP : ST_UKD;
         ST_UKD: begin
            if (subj_rd_ff.stop != dtime_ff) st_in = ST_PREP;
            else begin
               send_in = subj_rd_ff.strat_end;
               i_in = '0;
               st_in = (subj_rd_ff.evt && nv != '0) ? ST_UC : ST_UPOST;
            end
         end
         ST_UC: st_in = ST_UN;
         ST_UN: begin
            cov_v_in = cov_rd_ff;
            if (den2_ff == '0) begin
               mark_we = 1'b1;
               mark_wa = k_ff[SUBJ_W-1:0];
               mark_wc = ci;
               mark_wd = MARK_ZDIV;
               st_in = ST_UNEXT;
            end else begin
               mprod_in = mul_a * kf_ff;
               st_in = ST_UN2;
            end
         end
         ST_UN2: begin
            neg_in = nsh[DIV_W-1] ^ den2_ff[DIV_W-1];
            div_start = 1'b1;
            st_in = ST_DIV;
         end
         ST_DIV: if (div_done) st_in = ST_RES;
         ST_RES: begin
            r_in = neg_ff ? cov_ext + quot : cov_ext - quot;
            st_in = ST_WR;
         end
         ST_WR: begin
            cov_we = 1'b1;
            cov_wa = {k_ff[SUBJ_W-1:0], ci};
            mark_we = 1'b1;
            mark_wa = k_ff[SUBJ_W-1:0];
            mark_wc = ci;
            if ((&r_ff[DIV_W-1:31]) || !(|r_ff[DIV_W-1:31])) begin
               cov_wd = r_ff[31:0];
               mark_wd = MARK_NONE;
            end else begin
               cov_wd = r_ff[DIV_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               mark_wd = MARK_SAT;
            end
            st_in = ST_UNEXT;
         end
         ST_UNEXT: begin
            i_in = i_ff + ELEM_W'(1);
            st_in = (i_ff + ELEM_W'(1) < nv) ? ST_UC : ST_UPOST;
         end
         ST_UPOST: begin
            p_in = k_ff + CNT_W'(1);
            if (send_ff) st_in = ST_PREP;
            else begin
               k_in = k_ff + CNT_W'(1);
               st_in = ST_UK;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (subj_we) subj_mem[subj_wa] <= subj_wd;
      if (cov_we) cov_mem[cov_wa] <= cov_wd;
      if (mark_clr) mark_mem[mark_wa] <= '0;
      else if (mark_we) mark_mem[mark_wa][{mark_wc, 1'b0} +: 2] <= mark_wd;
      subj_rd_ff <= subj_mem[subj_ra];
      cov_rd_ff <= cov_mem[cov_ra];
      mark_rd_ff <= mark_mem[subj_ra];
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in; k_ff <= k_in; d_ff <= d_in;
      dtime_ff <= dtime_in; w_ff <= w_in; cov_v_ff <= cov_v_in;
      dies_ff <= dies_in; send_ff <= send_in; neg_ff <= neg_in; rd_ok_ff <= rd_ok_in;
      rd_cov_ff <= rd_cov_in;
      den0_ff <= den0_in; den1_ff <= den1_in; kf_ff <= kf_in;
      prod1_ff <= prod1_in; mprod_ff <= mprod_in; den2_ff <= den2_in; r_ff <= r_in;
      risk_ff <= risk_in; death_ff <= death_in;
      rsp_val_ff <= rsp_val_in; rsp_death_ff <= rsp_death_in;
      rsp_sat_ff <= rsp_sat_in; rsp_status_ff <= rsp_status_in;
      if (reset) begin
         st_ff <= ST_IDLE; phase_ff <= 1'b0; count_ff <= '0; elem_ff <= '0;
         i_ff <= '0;
         rsp_valid_ff <= 1'b0;
         num_cov_ff <= ELEM_W'(1); efron_ff <= 1'b0;
      end else begin
         st_ff <= st_in; phase_ff <= phase_in; count_ff <= count_in; elem_ff <= elem_in;
         i_ff <= i_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.index == CSR_NUM_COV)
            num_cov_ff <= ELEM_W'(csr_chan.data);
         if (csr_chan.valid && csr_chan.index == CSR_EFRON)
            efron_ff <= csr_chan.data[0];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.residual_value = rsp_val_ff;
   assign rsp_chan.is_death = rsp_death_ff;
   assign rsp_chan.saturated = rsp_sat_ff;
   assign rsp_chan.status = rsp_status_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> st_ff == ST_IDLE) else $error("ready outside idle");
   a_read_next: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_chan.kind == KIND_READ) |=> st_ff == ST_RD)
      else $error("read transfer not answered");
   a_rd_slot: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_RD |-> !rsp_valid_ff || rsp_chan.ready) else $error("result overwritten");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> st_ff == ST_DIV) else $error("divider done out of turn");
   a_cov_idx: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> i_ff <= ELEM_W'(MAX_COVARIATES)) else $error("covariate index");
endmodule
`default_nettype wire

// ----- tb/residual_checker.sv -----
// Checker for the Cox Schoenfeld residual block: watches the request, result and
// register channels, predicts every read answer and compares it field by field.
// Depends on coxsr_pkg and the three channel interfaces.
module residual_checker import coxsr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   coxsr_req_if      req_mon,
   coxsr_rsp_if      rsp_mon,
   coxsr_csr_if      csr_mon,
   output int        fail_count,
   output int        pending
);
   typedef struct packed {
      logic signed [31:0] value;
      logic               death;
      logic               sat;
      logic [1:0]         status;
   } entry_type;

   entry_type   awaited_q[$];
   logic [31:0] subj_start[MAX_SUBJECTS];
   logic [31:0] subj_stop[MAX_SUBJECTS];
   logic [31:0] subj_score[MAX_SUBJECTS];
   logic        subj_evt[MAX_SUBJECTS];
   logic        subj_last[MAX_SUBJECTS];
   logic [31:0] cov_tab[MAX_SUBJECTS*MAX_COVARIATES];
   logic [1:0]  mark_tab[MAX_SUBJECTS*MAX_COVARIATES];
   int unsigned subj_cnt;
   int unsigned elem_cnt;
   bit          computed;
   logic [3:0]  ncov_reg;
   logic        efron_reg;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic int unsigned active_covs();
      return (ncov_reg > MAX_COVARIATES) ? MAX_COVARIATES : ncov_reg;
   endfunction

   function automatic logic signed [63:0] weighted_cov(logic [31:0] w, logic [31:0] c);
      logic signed [63:0] p;
      p = $signed({32'b0, w}) * $signed({{32{c[31]}}, c});
      return p >>> Q_FRAC;
   endfunction

   function automatic void form_residuals();
      logic [63:0]         rs[MAX_COVARIATES];
      logic [63:0]         ds[MAX_COVARIATES];
      logic [63:0]         d0, d1;
      logic signed [127:0] a0, a1, kw, den2, num2, q, r, x;
      int unsigned         person, k, d, t, idx;
      int                  kf;
      int unsigned         nv;
      nv = active_covs();
      person = 0;
      while (person < subj_cnt) begin
         if (!subj_evt[person]) begin
            person++;
            continue;
         end
         t = subj_stop[person];
         for (int i = 0; i < MAX_COVARIATES; i++) begin
            rs[i] = '0;
            ds[i] = '0;
         end
         d0 = '0;
         d1 = '0;
         d = 0;
         for (k = person; k < subj_cnt; k++) begin
            if (subj_start[k] < t) begin
               d0 += subj_score[k];
               if (subj_stop[k] == t && subj_evt[k]) begin
                  d++;
                  d1 += subj_score[k];
               end
               for (int i = 0; i < nv; i++) begin
                  x = weighted_cov(subj_score[k], cov_tab[k*MAX_COVARIATES+i]);
                  rs[i] += x[63:0];
                  if (subj_stop[k] == t && subj_evt[k]) ds[i] += x[63:0];
               end
            end
            if (subj_last[k]) break;
         end
         kf = efron_reg ? int'(d) - 1 : 0;
         kw = kf;
         a0 = $signed({64'b0, d0});
         a1 = $signed({64'b0, d1});
         den2 = 2 * a0 - kw * a1;
         for (k = person; k < subj_cnt && subj_stop[k] == t; k++) begin
            if (subj_evt[k]) begin
               for (int i = 0; i < nv; i++) begin
                  idx = k * MAX_COVARIATES + i;
                  if (den2 == 0) begin
                     mark_tab[idx] = MARK_ZDIV;
                     continue;
                  end
                  a0 = $signed(rs[i]);
                  a1 = $signed(ds[i]);
                  num2 = 2 * a0 - kw * a1;
                  q = (num2 <<< Q_FRAC) / den2;
                  x = $signed(cov_tab[idx]);
                  r = x - q;
                  if (r > 128'sh7fffffff) begin
                     cov_tab[idx] = 32'h7fffffff;
                     mark_tab[idx] = MARK_SAT;
                  end else if (r < -128'sh80000000) begin
                     cov_tab[idx] = 32'h80000000;
                     mark_tab[idx] = MARK_SAT;
                  end else begin
                     cov_tab[idx] = r[31:0];
                     mark_tab[idx] = MARK_NONE;
                  end
               end
            end
            person++;
            if (subj_last[k]) break;
         end
      end
   endfunction

   function automatic void take_load();
      int unsigned s;
      if (computed) begin
         subj_cnt = 0;
         elem_cnt = 0;
         foreach (mark_tab[i]) mark_tab[i] = MARK_NONE;
         computed = 0;
      end
      if (subj_cnt < MAX_SUBJECTS) begin
         s = subj_cnt;
         subj_start[s] = req_mon.start_time;
         subj_stop[s] = req_mon.stop_time;
         subj_evt[s] = req_mon.event_flag;
         subj_last[s] = req_mon.stratum_end;
         subj_score[s] = req_mon.risk_score;
         if (elem_cnt < active_covs())
            cov_tab[s*MAX_COVARIATES+elem_cnt] = req_mon.covariate_value;
         if (elem_cnt < MAX_COVARIATES) elem_cnt++;
         if (req_mon.last_covariate || req_mon.last_subject) begin
            subj_cnt++;
            elem_cnt = 0;
         end
      end
      if (req_mon.last_subject) begin
         form_residuals();
         computed = 1;
      end
   endfunction

   function automatic entry_type look_up(int unsigned subj, int unsigned cv);
      entry_type e;
      int unsigned idx;
      e = '{value: '0, death: 1'b0, sat: 1'b0, status: STATUS_NONE};
      if (computed && subj < subj_cnt && cv < active_covs()) begin
         idx = subj * MAX_COVARIATES + cv;
         e.value = cov_tab[idx];
         e.death = subj_evt[subj];
         e.sat = mark_tab[idx][0];
         e.status = mark_tab[idx][1] ? STATUS_ZDIV : STATUS_OK;
      end
      return e;
   endfunction

   always @(posedge clock) begin : watch
      entry_type got, want;
      if (reset) begin
         subj_cnt = 0;
         elem_cnt = 0;
         computed = 0;
         ncov_reg = 4'd1;
         efron_reg = 1'b0;
         foreach (mark_tab[i]) mark_tab[i] = MARK_NONE;
         awaited_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_NUM_COV) ncov_reg = csr_mon.data;
            else if (csr_mon.index == CSR_EFRON) efron_reg = csr_mon.data[0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{value: rsp_mon.residual_value, death: rsp_mon.is_death,
                    sat: rsp_mon.saturated, status: rsp_mon.status};
            if (awaited_q.size() == 0) begin
               $error("result transfer with nothing awaited: value %h", got.value);
               fail_count++;
            end else begin
               want = awaited_q.pop_front();
               if (got.value !== want.value) begin
                  $error("residual_value: expected %h, actual %h", want.value, got.value);
                  fail_count++;
               end
               if (got.death !== want.death) begin
                  $error("is_death: expected %b, actual %b", want.death, got.death);
                  fail_count++;
               end
               if (got.sat !== want.sat) begin
                  $error("saturated: expected %b, actual %b", want.sat, got.sat);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_LOAD) take_load();
            else awaited_q.push_back(look_up(req_mon.read_subject, req_mon.read_covariate));
         end
      end
      pending = awaited_q.size();
   end
endmodule

// ----- tb/tb_cox_schoenfeld_residuals.sv -----
// Top of the Cox Schoenfeld residual testbench: clock, reset, stimulus and verdict.
// Depends on coxsr_pkg, the channel interfaces, the block and residual_checker.
module tb_cox_schoenfeld_residuals;
   import coxsr_pkg::*;

   localparam int IDLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 900;

   typedef struct {
      logic        kind;
      logic [31:0] t_start;
      logic [31:0] t_stop;
      logic        evt;
      logic        strat_end;
      logic [31:0] score;
      logic [31:0] cov;
      logic        last_cov;
      logic        last_subj;
      logic [9:0]  rd_subj;
      logic [2:0]  rd_cov;
   } req_item_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   send_idle;
   int   stall_pct;
   int   hold_cnt;
   int   idle_cycles;
   int   items_sent;
   int   loads_sent;
   int   reads_sent;
   int   sets_done;
   int   cur_ncov;
   logic [31:0] cov_plan[$];

   coxsr_req_if req_chan ();
   coxsr_rsp_if rsp_chan ();
   coxsr_csr_if csr_chan ();

   cox_schoenfeld_residuals i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   residual_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      forever @(negedge clock) begin
         if (hold_cnt > 0) begin
            rsp_chan.ready = 1'b0;
            hold_cnt--;
         end else begin
            rsp_chan.ready = ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [31:0] pick_cov();
      case ($urandom_range(0, 9))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2, 3: return $urandom;
         default: return $urandom_range(0, 32'h00100000) - 32'h00080000;
      endcase
   endfunction

   function automatic logic [31:0] pick_score();
      case ($urandom_range(0, 11))
         0: return 32'h0;
         1, 2: return $urandom;
         default: return $urandom_range(1, 32'h00040000);
      endcase
   endfunction

   task automatic send_req(input req_item_type it);
      while ($urandom_range(0, 99) < send_idle) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.kind = it.kind;
      req_chan.start_time = it.t_start;
      req_chan.stop_time = it.t_stop;
      req_chan.event_flag = it.evt;
      req_chan.stratum_end = it.strat_end;
      req_chan.risk_score = it.score;
      req_chan.covariate_value = it.cov;
      req_chan.last_covariate = it.last_cov;
      req_chan.last_subject = it.last_subj;
      req_chan.read_subject = it.rd_subj;
      req_chan.read_covariate = it.rd_cov;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (it.kind == KIND_LOAD) loads_sent++;
      else reads_sent++;
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic send_read(input int subj, input int cv);
      req_item_type it;
      it = '{kind: KIND_READ, t_start: $urandom, t_stop: $urandom, evt: 1'($urandom),
             strat_end: 1'($urandom), score: $urandom, cov: $urandom,
             last_cov: 1'($urandom), last_subj: 1'b0, rd_subj: 10'(subj), rd_cov: 3'(cv)};
      send_req(it);
   endtask

   task automatic load_subject(input logic [31:0] st, input logic [31:0] sp, input logic ev,
                               input logic se, input logic [31:0] sc, input int nelem,
                               input bit final_subj);
      req_item_type it;
      for (int e = 0; e < nelem; e++) begin
         it.kind = KIND_LOAD;
         it.rd_subj = 10'($urandom);
         it.rd_cov = 3'($urandom);
         it.last_subj = 1'b0;
         it.last_cov = 1'b0;
         it.cov = (e < cov_plan.size()) ? cov_plan[e] : pick_cov();
         if (e == nelem - 1) begin
            it.t_start = st;
            it.t_stop = sp;
            it.evt = ev;
            it.strat_end = se;
            it.score = sc;
            it.last_subj = final_subj;
            it.last_cov = final_subj ? 1'($urandom_range(0, 1)) : 1'b1;
         end else begin
            it.t_start = $urandom;
            it.t_stop = $urandom;
            it.evt = 1'($urandom);
            it.strat_end = 1'($urandom);
            it.score = $urandom;
         end
         send_req(it);
      end
      cov_plan.delete();
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data = val;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
      if (idx == CSR_NUM_COV)
         cur_ncov = (int'(val) > MAX_COVARIATES) ? MAX_COVARIATES : int'(val);
   endtask

   task automatic random_set(input int nsub);
      logic [31:0] t, st;
      logic        ev, se, prev_evt, prev_end;
      int          step, nelem, nv;
      nv = (cur_ncov < 1) ? 1 : cur_ncov;
      t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 200);
      prev_evt = 1'b1;
      prev_end = 1'b1;
      for (int s = 0; s < nsub; s++) begin
         step = $urandom_range(0, 2);
         if (prev_end) t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 200);
         else t = t + 32'(step);
         if (!prev_end && step == 0 && !prev_evt) ev = 1'b0;
         else ev = ($urandom_range(0, 2) != 0);
         se = (s == nsub - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) == 0);
         st = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, t);
         nelem = nv + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
         if (s > 0 && $urandom_range(0, 19) == 0)
            send_read($urandom_range(0, 1023), $urandom_range(0, 7));
         load_subject(st, t, ev, se, pick_score(), nelem, s == nsub - 1);
         prev_evt = ev;
         prev_end = se;
      end
      repeat ($urandom_range(6, 14)) begin
         if ($urandom_range(0, 9) == 0) send_read($urandom_range(0, 1023), $urandom_range(0, 7));
         else send_read($urandom_range(0, nsub - 1), $urandom_range(0, 7));
      end
      sets_done++;
   endtask

   initial begin : stimulus
      int base_items;
      int nsub;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_LOAD;
      req_chan.start_time = '0;
      req_chan.stop_time = '0;
      req_chan.event_flag = 1'b0;
      req_chan.stratum_end = 1'b0;
      req_chan.risk_score = '0;
      req_chan.covariate_value = '0;
      req_chan.last_covariate = 1'b0;
      req_chan.last_subject = 1'b0;
      req_chan.read_subject = '0;
      req_chan.read_covariate = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      send_idle = 0;
      stall_pct = 0;
      hold_cnt = 0;
      idle_cycles = 0;
      items_sent = 0;
      loads_sent = 0;
      reads_sent = 0;
      sets_done = 0;
      cur_ncov = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_read(0, 0);
      drain();
      write_reg(CSR_NUM_COV, 4'd2);
      write_reg(CSR_EFRON, 4'd1);
      cov_plan = '{32'h7fffffff, 32'h80000000};
      load_subject(32'd0, 32'd10, 1'b1, 1'b0, 32'h00010000, 2, 1'b0);
      cov_plan = '{32'h00020000, 32'hfffe0000};
      load_subject(32'd5, 32'd10, 1'b1, 1'b0, 32'h00018000, 3, 1'b0);
      load_subject(32'd20, 32'd10, 1'b1, 1'b0, 32'hffffffff, 2, 1'b0);
      load_subject(32'd0, 32'd30, 1'b0, 1'b1, 32'h00008000, 2, 1'b0);
      load_subject(32'd0, 32'd40, 1'b1, 1'b1, 32'h0, 2, 1'b0);
      cov_plan = '{32'h80000000, 32'h7fffffff};
      load_subject(32'd50, 32'd40, 1'b1, 1'b0, 32'h00010000, 2, 1'b0);
      cov_plan = '{32'h7fffffff, 32'h80000000};
      load_subject(32'd0, 32'd60, 1'b0, 1'b1, 32'hffffffff, 2, 1'b1);
      while (!req_chan.ready) @(negedge clock);
      hold_cnt = 400;
      for (int s = 0; s < 7; s++) begin
         for (int c = 0; c < 3; c++) send_read(s, c);
      end
      send_read(1023, 7);
      drain();

      base_items = items_sent;
      while (items_sent - base_items < RANDOM_ITEMS) begin
         case (sets_done % 4)
            0: begin send_idle = 0; stall_pct = 0; end
            1: begin send_idle = 62; stall_pct = 0; end
            2: begin send_idle = 0; stall_pct = 62; end
            default: begin send_idle = 31; stall_pct = 31; end
         endcase
         if (sets_done % 3 == 0) begin
            case ($urandom_range(0, 5))
               0: write_reg(CSR_NUM_COV, 4'd0);
               1: write_reg(CSR_NUM_COV, 4'd15);
               2: write_reg(CSR_NUM_COV, 4'd8);
               3: write_reg(CSR_NUM_COV, 4'd1);
               default: write_reg(CSR_NUM_COV, 4'($urandom_range(0, 15)));
            endcase
            write_reg(CSR_EFRON, 4'($urandom_range(0, 1)));
         end
         if (sets_done == 6) hold_cnt = 400;
         nsub = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 10);
         random_set(nsub);
         drain();
      end

      while (pending != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      $display("%0d load and %0d read transfers over %0d random data sets plus directed sets",
               loads_sent, reads_sent, sets_done);
      $display("register settings from none to all covariates, Breslow and Efron ties");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
